// ----- rtl/core/pitd_pkg.sv -----
// ----------------------------------------------------------------------------
// pitd_pkg
// Shared types and codes of the priority interval task dispatcher: the input
// and result beat layouts, operation codes and result kinds.
// ----------------------------------------------------------------------------
`default_nettype none

package pitd_pkg;

    // Field widths fixed by the beat layouts
    localparam int OP_W    = 3;
    localparam int PRIO_W  = 2;
    localparam int IVL_W   = 32;
    localparam int SID_W   = 8;
    localparam int NOW_W   = 32;
    localparam int KIND_W  = 2;
    localparam int TNUM_W  = 5;
    localparam int COUNT_W = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_REGISTER   = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_ENABLE = 3'd1;
    localparam logic [OP_W-1:0] OP_RUN        = 3'd2;
    localparam logic [OP_W-1:0] OP_STOP_ALL   = 3'd3;
    localparam logic [OP_W-1:0] OP_RESUME_ALL = 3'd4;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_DONE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DUE     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RUN_END = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [PRIO_W-1:0] task_priority;
        logic [IVL_W-1:0]  interval;
        logic [SID_W-1:0]  slot_id;
        logic              enable_value;
        logic [NOW_W-1:0]  now_ms;
    } t_in_beat;

    typedef struct packed {
        logic [KIND_W-1:0]  result_kind;
        logic [TNUM_W-1:0]  task_number;
        logic [COUNT_W-1:0] registered_count;
        logic [COUNT_W-1:0] enabled_count;
        logic               last_result;
    } t_out_beat;

endpackage

`default_nettype wire

// ----- rtl/core/pitd_ram.sv -----
// ----------------------------------------------------------------------------
// pitd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pitd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/pitd_due_unit.sv -----
// ----------------------------------------------------------------------------
// pitd_due_unit
// Shared due check: one modular subtract and one magnitude compare, reused for every
// slot the run sequence visits.
// ----------------------------------------------------------------------------
`default_nettype none

module pitd_due_unit #(
    parameter int TIME_BITS = 32
) (
    input  wire logic [TIME_BITS-1:0] i_interval,
    input  wire logic [TIME_BITS-1:0] i_last_run,
    input  wire logic [TIME_BITS-1:0] i_now,
    output logic                      o_due,
    output logic                      o_stamp
);

    logic [TIME_BITS-1:0] w_elapsed;
    logic                 w_ivl_zero;

    // elapsed time wraps modulo 2^TIME_BITS
    assign w_elapsed  = i_now - i_last_run;
    assign w_ivl_zero = (i_interval == '0);

    assign o_due   = w_ivl_zero || (i_last_run == '0) || (w_elapsed >= i_interval);
    // every-run tasks keep their last-run time
    assign o_stamp = !w_ivl_zero;

endmodule

`default_nettype wire

// ----- rtl/core/priority_interval_task_dispatcher_top.sv -----
// ----------------------------------------------------------------------------
// priority_interval_task_dispatcher_top
// Task slot table with register, enable, stop/resume and run operations. A run
// scans levels from the top down to 1 and slots in order, one due check at a
// time, and emits one beat per due task plus a closing beat.
// ----------------------------------------------------------------------------
//
//  channel  | valid       | stall       | payload
//  ---------+-------------+-------------+--------------------------
//  input    | i_in_valid  | o_in_stall  | i_in_data  (t_in_beat)
//  result   | o_out_valid | i_out_stall | o_out_data (t_out_beat)
//
//  Register: walks past occupied slots to the first free one, then replies;
//  on a full table it replies at once. Other non-run ops: execute, then reply.
//  Run: idle slots are skipped, live slots are read and then checked, over
//  levels PRIORITY_LEVELS-1 down to 1, then a closing beat is sent.
//  Reset clears the slot flags and counts; no clearing pass is needed.
//  A stalled result holds the scan in place until the beat is taken.
//
`default_nettype none

module priority_interval_task_dispatcher_top
    import pitd_pkg::*;
#(
    parameter int NUM_SLOTS       = 16,
    parameter int PRIORITY_LEVELS = 4,
    parameter int TIME_BITS       = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_beat  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_beat      o_out_data
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int LVL_W = $clog2(PRIORITY_LEVELS);
    localparam int CMP_W = (LVL_W > PRIO_W) ? LVL_W : PRIO_W;
    localparam int CFG_W = PRIO_W + TIME_BITS;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_REG_SCAN = 3'd1;
    localparam logic [2:0] S_EXEC     = 3'd2;
    localparam logic [2:0] S_DONE     = 3'd3;
    localparam logic [2:0] S_RUN_ADDR = 3'd4;
    localparam logic [2:0] S_RUN_CHK  = 3'd5;
    localparam logic [2:0] S_END      = 3'd6;

    logic [2:0]           r_state,    n_state;
    t_in_beat             r_item,     n_item;
    logic [IDX_W-1:0]     r_idx,      n_idx;
    logic [LVL_W-1:0]     r_lvl,      n_lvl;
    logic [NUM_SLOTS-1:0] r_used,     n_used;
    logic [NUM_SLOTS-1:0] r_en,       n_en;
    logic [CNT_W-1:0]     r_used_cnt, n_used_cnt;
    logic [CNT_W-1:0]     r_en_cnt,   n_en_cnt;
    logic [TNUM_W-1:0]    r_num,      n_num;
    logic                 r_out_valid;
    t_out_beat            r_out_data;

    logic                 w_out_free;
    logic                 w_emit;
    t_out_beat            w_emit_beat;
    logic                 w_advance;
    logic                 w_cfg_we;
    logic                 w_last_we;
    logic [CFG_W-1:0]     w_cfg_wdata;
    logic [CFG_W-1:0]     w_cfg_rdata;
    logic [TIME_BITS-1:0] w_last_wdata;
    logic [TIME_BITS-1:0] w_last_rdata;
    logic [TIME_BITS-1:0] w_ivl_in;
    logic [TIME_BITS-1:0] w_now;
    logic [PRIO_W-1:0]    w_slot_prio;
    logic [TIME_BITS-1:0] w_slot_ivl;
    logic                 w_prio_hit;
    logic                 w_due;
    logic                 w_stamp;
    logic                 w_sid_ok;
    logic [IDX_W-1:0]     w_sid_idx;

    // times and intervals are kept at TIME_BITS
    assign w_ivl_in    = TIME_BITS'(r_item.interval);
    assign w_now       = TIME_BITS'(r_item.now_ms);
    assign w_cfg_wdata = {r_item.task_priority, w_ivl_in};
    assign w_slot_prio = w_cfg_rdata[CFG_W-1 -: PRIO_W];
    assign w_slot_ivl  = w_cfg_rdata[TIME_BITS-1:0];
    assign w_prio_hit  = (CMP_W'(w_slot_prio) == CMP_W'(r_lvl));

    // set-enable slot id is the slot number plus one
    assign w_sid_ok  = (r_item.slot_id != '0) && (int'(r_item.slot_id) <= NUM_SLOTS);
    assign w_sid_idx = IDX_W'(r_item.slot_id - SID_W'(1));

    assign w_out_free = !r_out_valid || !i_out_stall;

    // slot priority and interval
    pitd_ram #(
        .WIDTH (CFG_W),
        .DEPTH (NUM_SLOTS)
    ) u_cfg_ram (
        .i_clk   (i_clk),
        .i_we    (w_cfg_we),
        .i_waddr (r_idx),
        .i_wdata (w_cfg_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_cfg_rdata)
    );

    // slot last-run time
    pitd_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (NUM_SLOTS)
    ) u_last_ram (
        .i_clk   (i_clk),
        .i_we    (w_last_we),
        .i_waddr (r_idx),
        .i_wdata (w_last_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_last_rdata)
    );

    pitd_due_unit #(
        .TIME_BITS (TIME_BITS)
    ) u_due (
        .i_interval (w_slot_ivl),
        .i_last_run (w_last_rdata),
        .i_now      (w_now),
        .o_due      (w_due),
        .o_stamp    (w_stamp)
    );

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_idx        = r_idx;
        n_lvl        = r_lvl;
        n_used       = r_used;
        n_en         = r_en;
        n_used_cnt   = r_used_cnt;
        n_en_cnt     = r_en_cnt;
        n_num        = r_num;
        w_emit       = 1'b0;
        w_advance    = 1'b0;
        w_cfg_we     = 1'b0;
        w_last_we    = 1'b0;
        w_last_wdata = '0;
        w_emit_beat.result_kind      = KIND_DONE;
        w_emit_beat.task_number      = '0;
        w_emit_beat.registered_count = COUNT_W'(r_used_cnt);
        w_emit_beat.enabled_count    = COUNT_W'(r_en_cnt);
        w_emit_beat.last_result      = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_data;
                    n_idx  = '0;
                    n_lvl  = LVL_W'(PRIORITY_LEVELS - 1);
                    n_num  = '0;
                    case (i_in_data.op)
                        OP_REGISTER: begin
                            n_state = (r_used_cnt < CNT_W'(NUM_SLOTS)) ? S_REG_SCAN : S_DONE;
                        end
                        OP_RUN:  n_state = S_RUN_ADDR;
                        default: n_state = S_EXEC;
                    endcase
                end
            end

            // walk to the first free slot; one exists when this state is entered
            S_REG_SCAN: begin
                if (!r_used[r_idx]) begin
                    n_used[r_idx] = 1'b1;
                    n_en[r_idx]   = 1'b1;
                    w_cfg_we      = 1'b1;
                    w_last_we     = 1'b1;
                    n_used_cnt    = r_used_cnt + 1'b1;
                    n_en_cnt      = r_en_cnt + 1'b1;
                    n_num         = TNUM_W'({1'b0, r_idx} + (IDX_W + 1)'(1));
                    n_state       = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_EXEC: begin
                case (r_item.op)
                    OP_SET_ENABLE: begin
                        if (w_sid_ok && r_used[w_sid_idx]) begin
                            n_en[w_sid_idx] = r_item.enable_value;
                            if (r_item.enable_value && !r_en[w_sid_idx]) begin
                                n_en_cnt = r_en_cnt + 1'b1;
                            end else if (!r_item.enable_value && r_en[w_sid_idx]) begin
                                n_en_cnt = r_en_cnt - 1'b1;
                            end
                        end
                    end
                    OP_STOP_ALL: begin
                        n_en     = r_en & ~r_used;
                        n_en_cnt = '0;
                    end
                    OP_RESUME_ALL: begin
                        n_en     = r_en | r_used;
                        n_en_cnt = r_used_cnt;
                    end
                    default: ;
                endcase
                n_state = S_DONE;
            end

            S_DONE: begin
                if (w_out_free) begin
                    w_emit                  = 1'b1;
                    w_emit_beat.task_number = r_num;
                    n_state                 = S_IDLE;
                end
            end

            // RAM read of r_idx happens here; only live slots go on to the check
            S_RUN_ADDR: begin
                if (r_used[r_idx] && r_en[r_idx]) begin
                    n_state = S_RUN_CHK;
                end else begin
                    w_advance = 1'b1;
                end
            end

            S_RUN_CHK: begin
                if (w_prio_hit && w_due) begin
                    if (w_out_free) begin
                        w_emit                  = 1'b1;
                        w_emit_beat.result_kind = KIND_DUE;
                        w_emit_beat.task_number =
                            TNUM_W'({1'b0, r_idx} + (IDX_W + 1)'(1));
                        w_emit_beat.last_result = 1'b0;
                        w_last_we               = w_stamp;
                        w_last_wdata            = w_now;
                        w_advance               = 1'b1;
                    end
                end else begin
                    w_advance = 1'b1;
                end
            end

            S_END: begin
                if (w_out_free) begin
                    w_emit                  = 1'b1;
                    w_emit_beat.result_kind = KIND_RUN_END;
                    n_state                 = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase

        // next slot, wrapping to the next lower level
        if (w_advance) begin
            if (r_idx == IDX_W'(NUM_SLOTS - 1)) begin
                n_idx = '0;
                if (r_lvl == LVL_W'(1)) begin
                    n_state = S_END;
                end else begin
                    n_lvl   = r_lvl - 1'b1;
                    n_state = S_RUN_ADDR;
                end
            end else begin
                n_idx   = r_idx + 1'b1;
                n_state = S_RUN_ADDR;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_en        <= '0;
            r_used_cnt  <= '0;
            r_en_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_en       <= n_en;
            r_used_cnt <= n_used_cnt;
            r_en_cnt   <= n_en_cnt;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_idx  <= n_idx;
        r_lvl  <= n_lvl;
        r_num  <= n_num;
        if (w_emit) begin
            r_out_data <= w_emit_beat;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire
